@@ rtl/core/rmst_pkg.sv @@
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types, opcodes and helpers for the range maximum tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

    localparam int POS_W = 10;
    localparam int END_W = 11;
    localparam int VAL_W = 32;

    typedef logic signed [VAL_W-1:0] value_t;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // result handed from the sequencer to the output stage
    typedef struct packed {
        logic   valid;
        value_t value;
    } res_t;

    function automatic value_t vmax(input value_t a, input value_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

@@ rtl/core/rmst_node_ram.sv @@
// ----------------------------------------------------------------------------
// rmst_node_ram
// Tree node storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rmst_node_ram
    import rmst_pkg::*;
#(
    parameter int AW = 11
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  value_t        wdata,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output value_t        rdata_a,
    output value_t        rdata_b
);

    localparam int DEPTH = 1 << AW;

    value_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/core/rmst_ctrl.sv @@
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer: clearing pass, leaf-to-root update walk, bottom-up range query.
// ----------------------------------------------------------------------------
module rmst_ctrl
    import rmst_pkg::*;
#(
    parameter int LEAVES = 1024,
    parameter int AW     = 11
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             opcode,
    input  logic [POS_W-1:0] position,
    input  logic [END_W-1:0] range_end,
    input  value_t           new_value,
    input  logic             cfg_wr_en,
    input  value_t           cfg_wr_data,
    output res_t             res,
    input  logic             res_ready,
    output logic             mem_we,
    output logic [AW-1:0]    mem_waddr,
    output value_t           mem_wdata,
    output logic [AW-1:0]    mem_raddr_a,
    output logic [AW-1:0]    mem_raddr_b,
    input  value_t           mem_rdata_a,
    input  value_t           mem_rdata_b
);

    localparam int SPAN = 1 << $clog2(LEAVES);
    localparam int IW   = AW + 1;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_UPD   = 3'd2;
    localparam logic [2:0] ST_QROOT = 3'd3;
    localparam logic [2:0] ST_QRY   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic          pend_a_reg, pend_a_next;
    logic          pend_b_reg, pend_b_next;
    value_t        ident_reg, ident_next;
    logic [AW-1:0] node_reg, node_next;
    value_t        cur_reg, cur_next;
    value_t        acc_reg, acc_next;
    logic [IW-1:0] l_reg, l_next;
    logic [IW-1:0] r_reg, r_next;

    logic [AW-1:0] leaf_addr;
    logic [AW-1:0] parent;
    logic [IW-1:0] lo_c, hi_c, r_m1;
    logic          pos_ok;
    value_t        up_max;
    value_t        acc_merge;

    assign in_ready  = (state_reg == ST_IDLE);
    assign pos_ok    = (32'(position) < 32'(LEAVES));
    assign leaf_addr = AW'(SPAN) + AW'(position);
    assign parent    = node_reg >> 1;
    assign up_max    = vmax(cur_reg, mem_rdata_a);
    assign r_m1      = r_reg - IW'(1);
    assign lo_c      = (32'(position) >= 32'(SPAN)) ? IW'(SPAN) : IW'(position);
    assign hi_c      = (32'(range_end) >= 32'(SPAN)) ? IW'(SPAN) : IW'(range_end);

    always_comb
    begin
        acc_merge = acc_reg;
        if (pend_a_reg)
        begin
            acc_merge = vmax(acc_merge, mem_rdata_a);
        end
        if (pend_b_reg)
        begin
            acc_merge = vmax(acc_merge, mem_rdata_b);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        pend_a_next = pend_a_reg;
        pend_b_next = pend_b_reg;
        ident_next  = cfg_wr_en ? cfg_wr_data : ident_reg;
        node_next   = node_reg;
        cur_next    = cur_reg;
        acc_next    = acc_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_raddr_a = '0;
        mem_raddr_b = '0;
        res.valid   = 1'b0;
        res.value   = acc_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (&clr_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_UPDATE)
                    begin
                        if (pos_ok)
                        begin
                            mem_we      = 1'b1;
                            mem_waddr   = leaf_addr;
                            mem_wdata   = new_value;
                            mem_raddr_a = leaf_addr ^ AW'(1);
                            node_next   = leaf_addr;
                            cur_next    = new_value;
                            state_next  = ST_UPD;
                        end
                    end
                    else if (lo_c >= hi_c)
                    begin
                        acc_next   = ident_reg;
                        state_next = ST_DONE;
                    end
                    else if (lo_c == '0 && hi_c == IW'(SPAN))
                    begin
                        // whole span: root alone, identity not mixed in
                        mem_raddr_a = AW'(1);
                        state_next  = ST_QROOT;
                    end
                    else
                    begin
                        l_next      = lo_c + IW'(SPAN);
                        r_next      = hi_c + IW'(SPAN);
                        acc_next    = ident_reg;
                        pend_a_next = 1'b0;
                        pend_b_next = 1'b0;
                        state_next  = ST_QRY;
                    end
                end
            end
            ST_UPD:
            begin
                mem_we      = 1'b1;
                mem_waddr   = parent;
                mem_wdata   = up_max;
                mem_raddr_a = parent ^ AW'(1);
                cur_next    = up_max;
                node_next   = parent;
                if (parent == AW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_QROOT:
            begin
                acc_next   = mem_rdata_a;
                state_next = ST_DONE;
            end
            ST_QRY:
            begin
                acc_next = acc_merge;
                if (l_reg < r_reg)
                begin
                    mem_raddr_a = l_reg[AW-1:0];
                    mem_raddr_b = r_m1[AW-1:0];
                    pend_a_next = l_reg[0];
                    pend_b_next = r_reg[0];
                    l_next      = (l_reg + IW'(l_reg[0])) >> 1;
                    r_next      = r_reg >> 1;
                end
                else
                begin
                    pend_a_next = 1'b0;
                    pend_b_next = 1'b0;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            pend_a_reg <= 1'b0;
            pend_b_reg <= 1'b0;
            ident_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            pend_a_reg <= pend_a_next;
            pend_b_reg <= pend_b_next;
            ident_reg  <= ident_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg <= node_next;
        cur_reg  <= cur_next;
        acc_reg  <= acc_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
    end

endmodule

@@ rtl/core/range_max_segment_tree.sv @@
// ----------------------------------------------------------------------------
// range_max_segment_tree
// Max segment tree in one node memory: point update, half-open range query.
//
// channel | signals                                        | moves
// in      | in_valid, in_ready, opcode, position,          | one item per op
//         | range_end, new_value                           |
// out     | out_valid, out_ready, max_value                | one item per query
// cfg     | cfg_wr_en, cfg_wr_data                         | identity value
//
// Update: one tree level per cycle through the memory write port. Query: one
// level per cycle on the two read ports. An update to a position >= LEAVES is
// dropped. After reset a clearing pass zeroes the memory, with in_ready low.
// The output register takes the next item's work while a result waits;
// a query result waiting there holds the following query at its end.
// ----------------------------------------------------------------------------
module range_max_segment_tree
    import rmst_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             opcode,
    input  logic [POS_W-1:0] position,
    input  logic [END_W-1:0] range_end,
    input  value_t           new_value,
    output logic             out_valid,
    input  logic             out_ready,
    output value_t           max_value,
    input  logic             cfg_wr_en,
    input  value_t           cfg_wr_data
);

    localparam int AW = $clog2(LEAVES) + 1;

    res_t          res;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    value_t        mem_wdata;
    logic [AW-1:0] mem_raddr_a;
    logic [AW-1:0] mem_raddr_b;
    value_t        mem_rdata_a;
    value_t        mem_rdata_b;

    logic   out_valid_reg, out_valid_next;
    value_t max_value_reg, max_value_next;

    rmst_ctrl #(
        .LEAVES (LEAVES),
        .AW     (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .position    (position),
        .range_end   (range_end),
        .new_value   (new_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res         (res),
        .res_ready   (res_ready),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr_a (mem_raddr_a),
        .mem_raddr_b (mem_raddr_b),
        .mem_rdata_a (mem_rdata_a),
        .mem_rdata_b (mem_rdata_b)
    );

    rmst_node_ram #(
        .AW (AW)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (mem_raddr_a),
        .raddr_b (mem_raddr_b),
        .rdata_a (mem_rdata_a),
        .rdata_b (mem_rdata_b)
    );

    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        max_value_next = max_value_reg;
        if (res.valid && res_ready)
        begin
            out_valid_next = 1'b1;
            max_value_next = res.value;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_value_reg <= max_value_next;
    end

    assign out_valid = out_valid_reg;
    assign max_value = max_value_reg;

endmodule

@@ rtl/core/rmst_checker.sv @@
// ----------------------------------------------------------------------------
// rmst_checker
// Port-level checks for the range maximum tree, bound to the top level.
// ----------------------------------------------------------------------------
module rmst_checker
    import rmst_pkg::*;
#(
    parameter int LEAVES = 1024
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             opcode,
    input logic [POS_W-1:0] position,
    input logic             out_valid,
    input logic             out_ready,
    input value_t           max_value
);

    // in_ready low right after reset, while the clearing pass runs
    a_clear_after_reset: assert property (@(posedge clk)
        !rst_n |=> !in_ready)
        else $error("in_ready high right after reset");

    // an update to a real leaf walks the tree before the next item
    a_update_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_UPDATE && 32'(position) < 32'(LEAVES)
        |=> !in_ready)
        else $error("update did not hold off the input");

    // a query always passes through its result step
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == OP_QUERY |=> !in_ready)
        else $error("query did not hold off the input");

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(max_value))
        else $error("result dropped or changed while stalled");

endmodule

bind range_max_segment_tree rmst_checker #(.LEAVES(LEAVES)) u_rmst_checker (.*);
